/* src/mscdt_pkg.sv */
// shared types and constants of the countdown timer bank
// no dependencies; imported by the controller, datapath and checker
package mscdt_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;
    localparam logic [2:0] OP_SETIV = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;
    localparam logic [2:0] OP_TIME  = 3'd7;

    // result kinds carried on tuser
    localparam logic KIND_DONE   = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // stream widths
    localparam int IN_W  = 24;
    localparam int OUT_W = 40;

    // expiry results per tick are capped at this count
    localparam logic [3:0] EXP_MAX = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the accepted input transaction
        logic exec;       // perform the execute-state part of the op
        logic load;       // start: countdown from reload data
        logic adv;        // tick sweep: finish current slot, step index
        logic emit_exp;   // load an expiry result into the output register
        logic emit_done;  // load the completion result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       exp_need;
        logic       out_free;
        logic       idx_last;
    } t_sts;

endpackage

/* src/mscdt_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies; used for the reload and countdown stores
module mscdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mscdt_ctrl.sv */
// controller state machine of the countdown timer bank
// depends on mscdt_pkg for the command and status structs and op codes
module mscdt_ctrl import mscdt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_TCHK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.op)
                    OP_TICK:  n_state = S_TRD;
                    OP_START: n_state = S_LOAD;
                    default:  n_state = S_DONE;
                endcase
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_DONE;
            end
            S_TRD: begin
                n_state = S_TCHK;
            end
            S_TCHK: begin
                // hold the slot while its expiry result cannot be placed
                o_cmd.adv      = !i_sts.exp_need || i_sts.out_free;
                o_cmd.emit_exp = i_sts.exp_need && i_sts.out_free;
                if (o_cmd.adv && i_sts.idx_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/mscdt_dp.sv */
// datapath of the countdown timer bank: flags, tick counter, slot stores, output register
// depends on mscdt_pkg and mscdt_ram
module mscdt_dp import mscdt_pkg::*; #(
    parameter int SLOTS     = 8,
    parameter int TICK_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [2:0]       i_op,
    input  logic [2:0]       i_slot,
    input  logic [15:0]      i_interval,
    input  logic             i_notify,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_out_kind,
    output logic [2:0]       o_out_slot,
    output logic             o_out_error,
    output logic             o_out_running,
    output logic [31:0]      o_out_time,
    output logic             o_out_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [TICK_BITS-1:0] t_tick;
    typedef logic [SW-1:0]        t_ix;

    // captured input transaction
    logic [2:0]  r_op;
    logic [2:0]  r_slot;
    logic [15:0] r_iv;
    logic        r_nt;

    // per-slot flags
    logic [SLOTS-1:0] r_alloc, n_alloc;
    logic [SLOTS-1:0] r_run, n_run;
    logic [SLOTS-1:0] r_ntf, n_ntf;
    logic [SLOTS-1:0] r_rld_vld, n_rld_vld;

    logic [31:0] r_tick;
    t_ix         r_idx;
    logic [3:0]  r_cnt;

    // completion fields
    logic [2:0] r_res_slot;
    logic       r_res_err;
    logic       r_res_run;

    // output register
    logic        r_out_vld;
    logic        r_out_kind;
    logic [2:0]  r_out_slot;
    logic        r_out_err;
    logic        r_out_run;
    logic [31:0] r_out_time;
    logic        r_out_last;

    logic  slot_ok;
    t_ix   slot_ix;
    logic  found;
    t_ix   free_ix;
    t_tick iv_t;
    t_tick prog;
    logic  idx_last;
    logic  active;
    logic  cd_zero;
    logic  out_free;
    logic  exp_need;

    logic  rld_we;
    t_ix   rld_waddr;
    t_tick rld_rdata;
    logic  cd_we;
    t_ix   cd_waddr;
    t_tick cd_wdata;
    t_ix   cd_raddr;
    t_tick cd_rdata;

    assign slot_ok = (32'(r_slot) < SLOTS);
    assign slot_ix = t_ix'(r_slot);

    // lowest free slot
    always_comb begin
        found   = 1'b0;
        free_ix = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                found   = 1'b1;
                free_ix = t_ix'(i);
            end
        end
    end

    // interval minus one, zero kept as zero
    assign iv_t = t_tick'(r_iv);
    assign prog = (iv_t == '0) ? '0 : iv_t - 1'b1;

    // tick sweep status
    assign idx_last = (r_idx == t_ix'(SLOTS - 1));
    assign active   = r_alloc[r_idx] & r_run[r_idx];
    assign cd_zero  = (cd_rdata == '0);
    assign out_free = !r_out_vld || i_out_ready;
    assign exp_need = active && cd_zero && r_ntf[r_idx] && (r_cnt < EXP_MAX);

    assign o_sts.op       = r_op;
    assign o_sts.exp_need = exp_need;
    assign o_sts.out_free = out_free;
    assign o_sts.idx_last = idx_last;

    // reload store: written by allocate and set interval
    assign rld_we    = i_cmd.exec && (((r_op == OP_ALLOC) && found) ||
                                      ((r_op == OP_SETIV) && slot_ok));
    assign rld_waddr = (r_op == OP_ALLOC) ? free_ix : slot_ix;

    mscdt_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (SLOTS)
    ) u_rld_ram (
        .i_clk   (i_clk),
        .i_we    (rld_we),
        .i_waddr (rld_waddr),
        .i_wdata (prog),
        .i_raddr (slot_ix),
        .o_rdata (rld_rdata)
    );

    // countdown store: loaded by start, decremented by the tick sweep
    assign cd_we    = (i_cmd.load && slot_ok) || (i_cmd.adv && active && !cd_zero);
    assign cd_waddr = i_cmd.load ? slot_ix : r_idx;
    assign cd_wdata = i_cmd.load ? (r_rld_vld[slot_ix] ? rld_rdata : '0)
                                 : cd_rdata - 1'b1;
    // read one slot ahead once the current slot is finished
    assign cd_raddr = (i_cmd.adv && !idx_last) ? t_ix'(r_idx + 1'b1) : r_idx;

    mscdt_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (SLOTS)
    ) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (cd_waddr),
        .i_wdata (cd_wdata),
        .i_raddr (cd_raddr),
        .o_rdata (cd_rdata)
    );

    // next flag values
    always_comb begin
        n_alloc   = r_alloc;
        n_run     = r_run;
        n_ntf     = r_ntf;
        n_rld_vld = r_rld_vld;
        if (i_cmd.exec) begin
            case (r_op)
                OP_ALLOC: begin
                    if (found) begin
                        n_alloc[free_ix]   = 1'b1;
                        n_ntf[free_ix]     = r_nt;
                        n_rld_vld[free_ix] = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (slot_ok) begin
                        n_alloc[slot_ix] = 1'b0;
                        n_run[slot_ix]   = 1'b0;
                    end
                end
                OP_STOP: begin
                    if (slot_ok) begin
                        n_run[slot_ix] = 1'b0;
                    end
                end
                OP_SETIV: begin
                    if (slot_ok) begin
                        n_rld_vld[slot_ix] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load && slot_ok) begin
            n_run[slot_ix] = 1'b1;
        end
        // expired slot stops
        if (i_cmd.adv && active && cd_zero) begin
            n_run[r_idx] = 1'b0;
        end
    end

    // input capture and completion fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_slot <= i_slot;
            r_iv   <= i_interval;
            r_nt   <= i_notify;
        end
        if (i_cmd.exec) begin
            r_res_slot <= ((r_op == OP_ALLOC) && found) ? 3'(free_ix) : 3'd0;
            r_res_err  <= (r_op == OP_ALLOC) && !found;
            r_res_run  <= (r_op == OP_QUERY) && slot_ok && r_run[slot_ix];
        end
    end

    // control state: flags, tick counter, sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc   <= '0;
            r_run     <= '0;
            r_ntf     <= '0;
            r_rld_vld <= '0;
            r_tick    <= '0;
            r_idx     <= '0;
            r_cnt     <= '0;
        end else begin
            r_alloc   <= n_alloc;
            r_run     <= n_run;
            r_ntf     <= n_ntf;
            r_rld_vld <= n_rld_vld;
            if (i_cmd.exec && (r_op == OP_TICK)) begin
                r_tick <= r_tick + 32'd1;
                r_idx  <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.adv && !idx_last) begin
                r_idx <= t_ix'(r_idx + 1'b1);
            end
            if (i_cmd.emit_exp) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_exp || i_cmd.emit_done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_exp) begin
            r_out_kind <= KIND_EXPIRY;
            r_out_slot <= 3'(r_idx);
            r_out_err  <= 1'b0;
            r_out_run  <= 1'b0;
            r_out_time <= r_tick;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_out_kind <= KIND_DONE;
            r_out_slot <= r_res_slot;
            r_out_err  <= r_res_err;
            r_out_run  <= r_res_run;
            r_out_time <= r_tick;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_kind    = r_out_kind;
    assign o_out_slot    = r_out_slot;
    assign o_out_error   = r_out_err;
    assign o_out_running = r_out_run;
    assign o_out_time    = r_out_time;
    assign o_out_last    = r_out_last;

endmodule

/* src/multi_slot_countdown_timer_bank.sv */
// top level of the countdown timer bank: stream ports, controller and datapath
// depends on mscdt_pkg, mscdt_ctrl, mscdt_dp (and mscdt_ram below it)
//
//   channel   direction  tdata fields (low bit up)                     side band
//   s_axis    in         op[2:0] slot[5:3] interval[21:6] notify[22]   -
//   m_axis    out        result_slot[2:0] error[3] running[4]          tuser=kind
//                        time_now[36:5]                                tlast=last
//
// one item at a time: after accept a control op passes the execute and done
// states, start adds a load state, and a tick adds a read state and a sweep
// visiting one slot per cycle unless stalled, via the countdown RAM read port.
// a result waiting in the output register does not block the next accept.
// i_rst_n is synchronous, active low; all flags and the tick count clear.
// m_axis backpressure stalls the sequence while an expiry or the completion waits on a full output register.
module multi_slot_countdown_timer_bank import mscdt_pkg::*; #(
    parameter int SLOTS     = 8,
    parameter int TICK_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // op, slot, interval, notify, pad
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // result_slot, error, running, time_now, pad
    output logic [0:0]       o_m_axis_tuser,   // kind
    output logic             o_m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    logic        out_kind;
    logic [2:0]  out_slot;
    logic        out_err;
    logic        out_run;
    logic [31:0] out_time;

    // sequencer
    mscdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // timer state and result register
    mscdt_dp #(
        .SLOTS     (SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_s_axis_tdata[2:0]),
        .i_slot        (i_s_axis_tdata[5:3]),
        .i_interval    (i_s_axis_tdata[21:6]),
        .i_notify      (i_s_axis_tdata[22]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_kind    (out_kind),
        .o_out_slot    (out_slot),
        .o_out_error   (out_err),
        .o_out_running (out_run),
        .o_out_time    (out_time),
        .o_out_last    (o_m_axis_tlast)
    );

    // result packing
    assign o_m_axis_tdata = {3'b000, out_time, out_run, out_err, out_slot};
    assign o_m_axis_tuser = out_kind;

endmodule

/* src/mscdt_chk.sv */
// port-level checker for the countdown timer bank, bound to the top level
// depends on mscdt_pkg and multi_slot_countdown_timer_bank
module mscdt_chk import mscdt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic [0:0]       o_m_axis_tuser,
    input logic             o_m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // an expiry is never the final result and carries no error or running flag
    a_exp_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == KIND_EXPIRY) |->
            !o_m_axis_tlast && !o_m_axis_tdata[3] && !o_m_axis_tdata[4])
        else $error("malformed expiry result");

    // a failed allocate reports slot zero
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |->
            (o_m_axis_tdata[2:0] == 3'd0) && o_m_axis_tlast)
        else $error("error result with nonzero slot");

endmodule

bind multi_slot_countdown_timer_bank mscdt_chk u_mscdt_chk (.*);
